[rtl/core/ali_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ali_pkg
// Types and constants for the ordered word list: request and response beats,
// opcodes, status codes and derived widths.
// ----------------------------------------------------------------------------
package ali_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_GET    = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    typedef struct packed {
        logic        [1:0]       opcode;
        logic        [POS_W-1:0] position;
        logic signed [31:0]      value;
    } req_t;

    typedef struct packed {
        logic signed [31:0]      read_value;
        logic        [POS_W-1:0] count;
        logic        [1:0]       status;
    } rsp_t;

endpackage
`default_nettype wire

[rtl/core/array_list_insert_remove_top.sv]
// append and failed requests go straight to the response; get waits for the registered
// memory read; insert and remove first shift the entries from the position upward.
// one request at a time; the shift moves one entry per cycle through the element memory,
// which has one write port and one registered read port.
// a new request is taken while the previous response still waits in the output register.
// reset clears the length to zero; the element memory is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_insert_remove_top
// Fixed-capacity ordered list of signed words held in a synchronous memory:
// append, insert with shift up, remove with shift down, get.
// ----------------------------------------------------------------------------
module array_list_insert_remove_top
    import ali_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic req_valid,
    output logic       req_stall,
    input  wire  req_t req,
    output logic       rsp_valid,
    input  wire  logic rsp_stall,
    output rsp_t       rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SHIFT  = 2'd1;
    localparam logic [1:0] S_GETW   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [31:0] mem [CAPACITY];
    logic [31:0] rdata_reg;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             dir_reg, dir_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_addr_reg, pend_addr_next;
    logic [31:0]      val_reg, val_next;
    logic [31:0]      rd_reg, rd_next;
    logic [1:0]       sts_reg, sts_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;
    logic [IDX_W-1:0] raddr;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CNT_W-1:0] pos_cnt;
    logic [CNT_W-1:0] cur_dec;
    logic [CNT_W-1:0] cur_inc;
    logic             full;

    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_cnt = pos_ext[CNT_W-1:0];
    assign cur_dec = cursor_reg - CNT_W'(1);
    assign cur_inc = cursor_reg + CNT_W'(1);
    assign full    = (count_reg >= CNT_W'(CAPACITY));

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        lim_next       = lim_reg;
        pos_next       = pos_reg;
        dir_next       = dir_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        val_next       = val_reg;
        rd_next        = rd_reg;
        sts_next       = sts_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        raddr          = '0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    rd_next   = '0;
                    sts_next  = STS_OK;
                    pend_next = 1'b0;
                    val_next  = req.value;
                    unique case (req.opcode)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                sts_next = STS_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = count_reg[IDX_W-1:0];
                                wdata      = req.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_FINISH;
                        end
                        OP_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                sts_next   = STS_RANGE;
                                state_next = S_FINISH;
                            end
                            else if (full)
                            begin
                                sts_next   = STS_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                cursor_next = count_reg;
                                pos_next    = pos_cnt;
                                dir_next    = 1'b0;
                                count_next  = count_reg + CNT_W'(1);
                                state_next  = S_SHIFT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                sts_next   = STS_RANGE;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                cursor_next = pos_cnt + CNT_W'(1);
                                lim_next    = count_reg;
                                dir_next    = 1'b1;
                                count_next  = count_reg - CNT_W'(1);
                                state_next  = S_SHIFT;
                            end
                        end
                        OP_GET:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                sts_next   = STS_RANGE;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                raddr      = pos_cnt[IDX_W-1:0];
                                state_next = S_GETW;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // write back the word read in the previous cycle
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pend_addr_reg;
                    wdata = rdata_reg;
                end
                if (!dir_reg)
                begin
                    // insert: walk down from the top, each word moves up one slot
                    if (cursor_reg > pos_reg)
                    begin
                        raddr          = cur_dec[IDX_W-1:0];
                        pend_next      = 1'b1;
                        pend_addr_next = cursor_reg[IDX_W-1:0];
                        cursor_next    = cur_dec;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            we         = 1'b1;
                            waddr      = pos_reg[IDX_W-1:0];
                            wdata      = val_reg;
                            state_next = S_FINISH;
                        end
                    end
                end
                else
                begin
                    // remove: walk up from the hole, each word moves down one slot
                    if (cursor_reg < lim_reg)
                    begin
                        raddr          = cursor_reg[IDX_W-1:0];
                        pend_next      = 1'b1;
                        pend_addr_next = cur_dec[IDX_W-1:0];
                        cursor_next    = cur_inc;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_GETW:
            begin
                rd_next    = rdata_reg;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next      = 1'b1;
                    out_next.read_value = rd_reg;
                    out_next.count      = cnt_ext[POS_W-1:0];
                    out_next.status     = sts_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // element memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg    <= cursor_next;
        lim_reg       <= lim_next;
        pos_reg       <= pos_next;
        dir_reg       <= dir_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        rd_reg        <= rd_next;
        sts_reg       <= sts_next;
        out_reg       <= out_next;
    end

endmodule
`default_nettype wire
